// ===== sv/u8d_pkg.sv =====
// u8d_pkg: shared types and constants for the utf-8 decoder
// no dependencies; used by the interfaces, u8d_step and utf8_decoder
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int unsigned CP_W = 21;

    // sequence length codes, counted in continuation bytes
    localparam logic [1:0] C_LEN_NONE  = 2'd0;
    localparam logic [1:0] C_LEN_2BYTE = 2'd1;
    localparam logic [1:0] C_LEN_3BYTE = 2'd2;
    localparam logic [1:0] C_LEN_4BYTE = 2'd3;

    localparam logic [CP_W-1:0] C_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] C_MIN_2BYTE   = 21'h000080;
    localparam logic [CP_W-1:0] C_MIN_3BYTE   = 21'h000800;
    localparam logic [CP_W-1:0] C_MIN_4BYTE   = 21'h010000;
    localparam logic [CP_W-1:0] C_SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] C_SURR_END    = 21'h00E000;
    localparam logic [CP_W-1:0] C_CP_END      = 21'h110000;

    typedef struct packed {
        logic [1:0]      pending_count;
        logic [1:0]      sequence_length;
        logic [CP_W-1:0] partial_value;
    } t_dec_state;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        logic            bad_sequence;
    } t_dec_result;

endpackage

// ===== sv/u8d_if.sv =====
// u8d_if: valid/ready channel interfaces for the utf-8 decoder
// depends on u8d_pkg
`timescale 1ns / 1ps

interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if;
    logic                      valid;
    logic                      ready;
    logic [u8d_pkg::CP_W-1:0]  code_point;
    logic                      bad_sequence;

    modport source (output valid, output code_point, output bad_sequence, input ready);
    modport sink   (input valid, input code_point, input bad_sequence, output ready);
endinterface

// ===== sv/u8d_step.sv =====
// u8d_step: one-byte decode step, current state and byte in, next state and result out
// depends on u8d_pkg
`timescale 1ns / 1ps

module u8d_step (
    input  u8d_pkg::t_dec_state  i_state,
    input  logic [7:0]           i_byte,
    output u8d_pkg::t_dec_state  o_state,
    output u8d_pkg::t_dec_result o_result
);

    localparam u8d_pkg::t_dec_state C_IDLE = '{
        pending_count:   2'd0,
        sequence_length: u8d_pkg::C_LEN_NONE,
        partial_value:   '0
    };

    logic [u8d_pkg::CP_W-1:0] w_shifted;
    logic [1:0]               w_pending;
    logic                     w_value_ok;

    assign w_shifted = {i_state.partial_value[u8d_pkg::CP_W-7:0], i_byte[5:0]};
    assign w_pending = i_state.pending_count - 2'd1;

    // range, overlong and surrogate checks on the finished value
    always_comb begin
        unique case (i_state.sequence_length)
            u8d_pkg::C_LEN_2BYTE: w_value_ok = (w_shifted >= u8d_pkg::C_MIN_2BYTE);
            u8d_pkg::C_LEN_3BYTE: w_value_ok = (w_shifted >= u8d_pkg::C_MIN_3BYTE)
                && ((w_shifted < u8d_pkg::C_SURR_LO) || (w_shifted >= u8d_pkg::C_SURR_END));
            u8d_pkg::C_LEN_4BYTE: w_value_ok = (w_shifted >= u8d_pkg::C_MIN_4BYTE)
                && (w_shifted < u8d_pkg::C_CP_END);
            default:              w_value_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_state               = i_state;
        o_result.valid        = 1'b0;
        o_result.code_point   = u8d_pkg::C_REPLACEMENT;
        o_result.bad_sequence = 1'b1;
        if (i_state.pending_count == 2'd0) begin
            if (i_byte[7] == 1'b0) begin
                o_result.valid        = 1'b1;
                o_result.code_point   = {13'd0, i_byte};
                o_result.bad_sequence = 1'b0;
            end else if (i_byte[7:5] == 3'b110) begin
                o_state.sequence_length = u8d_pkg::C_LEN_2BYTE;
                o_state.pending_count   = u8d_pkg::C_LEN_2BYTE;
                o_state.partial_value   = {16'd0, i_byte[4:0]};
            end else if (i_byte[7:4] == 4'b1110) begin
                o_state.sequence_length = u8d_pkg::C_LEN_3BYTE;
                o_state.pending_count   = u8d_pkg::C_LEN_3BYTE;
                o_state.partial_value   = {17'd0, i_byte[3:0]};
            end else if (i_byte[7:3] == 5'b11110) begin
                o_state.sequence_length = u8d_pkg::C_LEN_4BYTE;
                o_state.pending_count   = u8d_pkg::C_LEN_4BYTE;
                o_state.partial_value   = {18'd0, i_byte[2:0]};
            end else begin
                o_result.valid = 1'b1;
            end
        end else if (i_byte[7:6] != 2'b10) begin
            // broken sequence: drop it and swallow this byte
            o_state        = C_IDLE;
            o_result.valid = 1'b1;
        end else if (w_pending != 2'd0) begin
            o_state.pending_count = w_pending;
            o_state.partial_value = w_shifted;
        end else begin
            o_state        = C_IDLE;
            o_result.valid = 1'b1;
            if (w_value_ok) begin
                o_result.code_point   = w_shifted;
                o_result.bad_sequence = 1'b0;
            end
        end
    end

endmodule

// ===== sv/utf8_decoder.sv =====
// utf8_decoder: streaming utf-8 to code point decoder, one byte per transaction
// throughput: one byte per cycle while the result register is free or o_cp.ready is high
// the byte path runs input register -> u8d_step -> result register
// bytes that only open or extend a sequence give no output transaction
// reset (i_rst_n low, synchronous) empties both registers and closes any open sequence
// depends on u8d_pkg, u8d_if and u8d_step
`timescale 1ns / 1ps

module utf8_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    u8d_byte_if.sink       i_byte,
    u8d_cp_if.source       o_cp
);

    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    u8d_pkg::t_dec_state      r_state;
    u8d_pkg::t_dec_state      n_state;
    u8d_pkg::t_dec_result     w_result;
    logic                     r_out_valid;
    logic [u8d_pkg::CP_W-1:0] r_out_cp;
    logic                     r_out_bad;
    logic                     w_out_free;
    logic                     w_adv;

    u8d_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (w_result)
    );

    assign w_out_free   = !r_out_valid || o_cp.ready;
    assign w_adv        = r_in_valid && w_out_free;
    assign i_byte.ready = !r_in_valid || w_adv;

    assign o_cp.valid        = r_out_valid;
    assign o_cp.code_point   = r_out_cp;
    assign o_cp.bad_sequence = r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (w_adv) begin
                r_state <= n_state;
            end
            if (w_out_free) begin
                r_out_valid <= w_adv && w_result.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.in_byte;
        end
        if (w_adv && w_result.valid) begin
            r_out_cp  <= w_result.code_point;
            r_out_bad <= w_result.bad_sequence;
        end
    end

    // idle decoder holds no leftover payload
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pending_count == 2'd0 |->
            r_state.sequence_length == u8d_pkg::C_LEN_NONE && r_state.partial_value == '0)
        else $error("idle decoder state not cleared");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pending_count != 2'd0 |->
            r_state.sequence_length >= r_state.pending_count)
        else $error("more continuation bytes pending than sequence holds");

    a_bad_is_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cp.valid && o_cp.bad_sequence |-> o_cp.code_point == u8d_pkg::C_REPLACEMENT)
        else $error("error result without replacement character");

    a_good_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cp.valid && !o_cp.bad_sequence |->
            o_cp.code_point < u8d_pkg::C_CP_END
            && (o_cp.code_point < u8d_pkg::C_SURR_LO || o_cp.code_point >= u8d_pkg::C_SURR_END))
        else $error("good result is not a unicode scalar value");

    // a sequence can only advance when a transaction is taken from the input register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("decoder state changed without a transaction");

endmodule

// ===== test/tb_utf8_decoder.sv =====
// tb_utf8_decoder: self-checking bench for the streaming utf-8 decoder
// predicts each code point from the accepted bytes and compares every output transaction
// depends on u8d_pkg, u8d_if and utf8_decoder
`timescale 1ns / 1ps

module tb_utf8_decoder;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_BYTES = 650;
    localparam int unsigned TAIL_BYTES = 60;
    localparam int unsigned HOLD_AFTER = 120;
    localparam int unsigned HOLD_CYCLES = 120;

    typedef struct {
        logic [u8d_pkg::CP_W-1:0] code_point;
        logic                     bad_sequence;
    } t_cp_expect;

    logic i_clk;
    logic i_rst_n;

    u8d_byte_if byte_bus ();
    u8d_cp_if   cp_bus ();

    utf8_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .o_cp    (cp_bus)
    );

    // decoder shadow state
    logic [1:0]               dec_pending;
    logic [1:0]               dec_len;
    logic [u8d_pkg::CP_W-1:0] dec_acc;

    logic [7:0] byte_stream [$];
    t_cp_expect expected_cps [$];

    logic       slot_full;
    logic [7:0] slot_byte;
    logic       byte_taken;
    logic       long_hold;
    logic       quiet_tail;
    int         send_gap;
    int         stall_left;
    int         idle_odds;
    int         cycle_count;
    int         bytes_in;
    int         cps_checked;
    int         bad_seen;
    int         mismatch_count;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // advance the shadow decoder by one byte; returns 1 when a code point comes out
    function automatic bit decode_byte(input logic [7:0] b, output t_cp_expect res);
        logic [u8d_pkg::CP_W-1:0] v;
        logic [1:0]               len;
        bit                       ok;
        res.code_point   = u8d_pkg::C_REPLACEMENT;
        res.bad_sequence = 1'b1;
        if (dec_pending == 2'd0) begin
            if (b[7] == 1'b0) begin
                res.code_point   = {13'd0, b};
                res.bad_sequence = 1'b0;
                return 1'b1;
            end
            if ((b & 8'hE0) == 8'hC0) begin
                dec_len = u8d_pkg::C_LEN_2BYTE;
                dec_acc = {16'd0, b[4:0]};
            end else if ((b & 8'hF0) == 8'hE0) begin
                dec_len = u8d_pkg::C_LEN_3BYTE;
                dec_acc = {17'd0, b[3:0]};
            end else if ((b & 8'hF8) == 8'hF0) begin
                dec_len = u8d_pkg::C_LEN_4BYTE;
                dec_acc = {18'd0, b[2:0]};
            end else begin
                return 1'b1;
            end
            dec_pending = dec_len;
            return 1'b0;
        end
        // anything but a continuation byte kills the sequence and is swallowed
        if ((b & 8'hC0) != 8'h80) begin
            dec_pending = 2'd0;
            dec_len     = u8d_pkg::C_LEN_NONE;
            dec_acc     = '0;
            return 1'b1;
        end
        dec_acc     = {dec_acc[u8d_pkg::CP_W-7:0], b[5:0]};
        dec_pending = dec_pending - 2'd1;
        if (dec_pending != 2'd0)
            return 1'b0;
        v       = dec_acc;
        len     = dec_len;
        dec_len = u8d_pkg::C_LEN_NONE;
        dec_acc = '0;
        case (len)
            u8d_pkg::C_LEN_2BYTE: ok = (v >= u8d_pkg::C_MIN_2BYTE);
            u8d_pkg::C_LEN_3BYTE: ok = (v >= u8d_pkg::C_MIN_3BYTE)
                && (v < u8d_pkg::C_SURR_LO || v >= u8d_pkg::C_SURR_END);
            u8d_pkg::C_LEN_4BYTE: ok = (v >= u8d_pkg::C_MIN_4BYTE)
                && (v < u8d_pkg::C_CP_END);
            default:              ok = 1'b0;
        endcase
        if (ok) begin
            res.code_point   = v;
            res.bad_sequence = 1'b0;
        end
        return 1'b1;
    endfunction

    // queue a code point as a lead byte plus nconts continuation bytes
    task automatic push_encoded(input logic [20:0] cp, input int nconts);
        case (nconts)
            0: byte_stream.push_back({1'b0, cp[6:0]});
            1: byte_stream.push_back({3'b110, cp[10:6]});
            2: byte_stream.push_back({4'b1110, cp[15:12]});
            default: byte_stream.push_back({5'b11110, cp[20:18]});
        endcase
        for (int k = nconts - 1; k >= 0; k--)
            byte_stream.push_back({2'b10, cp[6*k +: 6]});
    endtask

    task automatic build_stream();
        int          r;
        int          n;
        logic [7:0]  lead;
        logic [7:0]  directed [] = '{
            8'h00, 8'h7F,                   // ascii extremes
            8'hC2, 8'h80,                   // smallest two-byte value
            8'hC0, 8'h80,                   // overlong two-byte form
            8'hEF, 8'hBF, 8'hBF,            // largest three-byte value
            8'hED, 8'hA0, 8'h80,            // surrogate
            8'hF4, 8'h8F, 8'hBF, 8'hBF,     // largest scalar value
            8'hF4, 8'h90, 8'h80, 8'h80,     // beyond the code space
            8'h80, 8'hFF,                   // stray continuation, illegal lead
            8'hC3, 8'h41                    // broken sequence, the 'A' is swallowed
        };
        foreach (directed[k])
            byte_stream.push_back(directed[k]);
        while (byte_stream.size() < directed.size() + RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 22) begin
                push_encoded(21'($urandom_range(0, 8'h7F)), 0);
            end else if (r < 40) begin
                push_encoded(21'($urandom_range(8'h80, 11'h7FF)), 1);
            end else if (r < 56) begin
                push_encoded(21'($urandom_range(12'h800, 16'hFFFF)), 2);
            end else if (r < 70) begin
                push_encoded(21'($urandom_range(17'h10000, 21'h10FFFF)), 3);
            end else if (r < 80) begin
                // random payload: overlong, surrogate and out-of-range forms turn up here
                lead = 8'(($urandom_range(8'hC0, 8'hF7)));
                n    = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
                byte_stream.push_back(lead);
                repeat (n) byte_stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else if (r < 90) begin
                lead = 8'($urandom_range(8'hC0, 8'hF7));
                n    = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
                byte_stream.push_back(lead);
                repeat ($urandom_range(0, n - 1))
                    byte_stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
                // break it with anything outside 80-BF
                if ($urandom_range(0, 1))
                    byte_stream.push_back(8'($urandom_range(8'h00, 8'h7F)));
                else
                    byte_stream.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            end else begin
                byte_stream.push_back(8'($urandom));
            end
        end
    endtask

    // byte driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            quiet_tail = (byte_stream.size() < TAIL_BYTES);
            if (byte_taken) begin
                byte_taken = 1'b0;
                slot_full  = 1'b0;
            end
            if (!slot_full) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!quiet_tail && !long_hold && idle_odds != 0
                             && $urandom_range(0, 15) < idle_odds * 2) begin
                    send_gap = $urandom_range(1, 18) - 1;
                end else if (byte_stream.size() != 0) begin
                    slot_byte = byte_stream.pop_front();
                    slot_full = 1'b1;
                end
            end
            byte_bus.valid   <= slot_full;
            byte_bus.in_byte <= slot_byte;
        end
    end

    // result receiver back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0)
                stall_left--;
            else if (!quiet_tail && idle_odds != 0 && $urandom_range(0, 15) < idle_odds * 2)
                stall_left = $urandom_range(1, 18);
            cp_bus.ready <= !long_hold && stall_left == 0;
        end
    end

    // monitor: check results, then predict from the byte taken at this edge
    always @(posedge i_clk) begin
        t_cp_expect want;
        t_cp_expect got;
        if (i_rst_n) begin
            if (cp_bus.valid && cp_bus.ready) begin
                got.code_point   = cp_bus.code_point;
                got.bad_sequence = cp_bus.bad_sequence;
                cps_checked++;
                if (got.bad_sequence === 1'b1)
                    bad_seen++;
                if (expected_cps.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected transaction, code_point %h bad_sequence %b",
                             $time, got.code_point, got.bad_sequence);
                end else begin
                    want = expected_cps.pop_front();
                    if (got.code_point !== want.code_point) begin
                        mismatch_count++;
                        $display("%0t: code_point expected %h actual %h",
                                 $time, want.code_point, got.code_point);
                    end
                    if (got.bad_sequence !== want.bad_sequence) begin
                        mismatch_count++;
                        $display("%0t: bad_sequence expected %b actual %b",
                                 $time, want.bad_sequence, got.bad_sequence);
                    end
                end
            end
            if (byte_bus.valid && byte_bus.ready) begin
                byte_taken = 1'b1;
                bytes_in++;
                if (decode_byte(byte_bus.in_byte, want))
                    expected_cps.push_back(want);
            end
        end
    end

    // cycle budget, and a new idling mood every so often
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count % 128 == 0)
            idle_odds = $urandom_range(0, 3);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one long receiver hold-off so the decoder backs up into its input
    initial begin
        long_hold = 1'b0;
        wait (bytes_in >= HOLD_AFTER);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold = 1'b0;
    end

    initial begin
        i_rst_n          = 1'b0;
        byte_bus.valid   = 1'b0;
        byte_bus.in_byte = 8'h00;
        cp_bus.ready     = 1'b0;
        dec_pending      = 2'd0;
        dec_len          = u8d_pkg::C_LEN_NONE;
        dec_acc          = '0;
        slot_full        = 1'b0;
        slot_byte        = 8'h00;
        byte_taken       = 1'b0;
        quiet_tail       = 1'b0;
        send_gap         = 0;
        stall_left       = 0;
        idle_odds        = 2;
        cycle_count      = 0;
        bytes_in         = 0;
        cps_checked      = 0;
        bad_seen         = 0;
        mismatch_count   = 0;
        build_stream();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (byte_stream.size() != 0 || slot_full)
            @(posedge i_clk);
        while (expected_cps.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (expected_cps.size() != 0)
            mismatch_count++;
        $display("decoded %0d bytes into %0d code points, %0d of them replacements",
                 bytes_in, cps_checked, bad_seen);
        $display("covered ascii, all sequence lengths, overlong, surrogate, range and breaks");
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/u8d_pkg.sv
sv/u8d_if.sv
sv/u8d_step.sv
sv/utf8_decoder.sv
test/tb_utf8_decoder.sv
